// ----- design/csdm_pkg.sv -----
// Package: constants, types and angle table for the concentric square-to-disk map.
package csdm_pkg;

	localparam int FRAC_BITS       = 14;
	localparam int ROTATION_STAGES = 16;
	localparam int ANGLE_FRAC      = 30;
	localparam int IO_W            = 16;
	localparam int MAG_W           = 16;
	localparam int QUO_W           = ANGLE_FRAC + 1;
	localparam int DIV_STEPS       = ANGLE_FRAC;
	localparam int GAIN_W          = 32;
	localparam int CW              = 34;
	localparam int ZW              = 33;
	localparam int OUT_SH          = ANGLE_FRAC - FRAC_BITS;
	localparam int OW              = CW - OUT_SH;

	localparam logic [29:0] PI_QUARTER_Q30 = 30'd843314857;
	localparam logic [29:0] GAIN_Q30       = 30'd652032874;

	typedef enum logic [1:0] {
		WEDGE_E = 2'd0,
		WEDGE_N = 2'd1,
		WEDGE_W = 2'd2,
		WEDGE_S = 2'd3
	} wedge_t;

	typedef struct packed {
		wedge_t              wedge;
		logic                zero;
		logic                qsign;
		logic [GAIN_W-1:0]   vx0;
	} div_side_t;

	typedef struct packed {
		wedge_t wedge;
		logic   zero;
	} rot_side_t;

	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] v;
		case (i)
			0:  v = 30'd843314857;
			1:  v = 30'd497837829;
			2:  v = 30'd263043837;
			3:  v = 30'd133525159;
			4:  v = 30'd67021687;
			5:  v = 30'd33543516;
			6:  v = 30'd16775851;
			7:  v = 30'd8388437;
			8:  v = 30'd4194283;
			9:  v = 30'd2097149;
			10: v = 30'd1048576;
			11: v = 30'd524288;
			12: v = 30'd262144;
			13: v = 30'd131072;
			14: v = 30'd65536;
			15: v = 30'd32768;
			16: v = 30'd16384;
			17: v = 30'd8192;
			18: v = 30'd4096;
			19: v = 30'd2048;
			20: v = 30'd1024;
			21: v = 30'd512;
			22: v = 30'd256;
			23: v = 30'd128;
			24: v = 30'd64;
			25: v = 30'd32;
			26: v = 30'd16;
			27: v = 30'd8;
			28: v = 30'd4;
			29: v = 30'd2;
			30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- design/csdm_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage.
module csdm_divider import csdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MAG_W-1:0]  in_rem,
	input  logic [MAG_W-1:0]  in_den,
	input  logic [QUO_W-1:0]  in_quo,
	input  div_side_t         in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [QUO_W-1:0]  out_quo,
	output div_side_t         out_side
);

	logic [DIV_STEPS:0] vld_q;
	logic [DIV_STEPS:0] rdy;
	logic [MAG_W-1:0]   rem_q  [DIV_STEPS+1];
	logic [MAG_W-1:0]   den_q  [DIV_STEPS+1];
	logic [QUO_W-1:0]   quo_q  [DIV_STEPS+1];
	div_side_t          side_q [DIV_STEPS+1];

	assign vld_q[0]  = in_valid;
	assign rem_q[0]  = in_rem;
	assign den_q[0]  = in_den;
	assign quo_q[0]  = in_quo;
	assign side_q[0] = in_side;
	assign rdy[0]    = 1'b0;
	assign in_ready  = rdy[1];

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [MAG_W:0]   rem2;
		logic             ge;
		logic [MAG_W:0]   diff;

		if (k == DIV_STEPS) begin : g_last
			assign rdy[k] = !vld_q[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !vld_q[k] || rdy[k+1];
		end

		assign rem2 = {rem_q[k-1], 1'b0};
		assign ge   = rem2 >= {1'b0, den_q[k-1]};
		assign diff = rem2 - {1'b0, den_q[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_q[k-1]) begin
				rem_q[k]  <= ge ? diff[MAG_W-1:0] : rem2[MAG_W-1:0];
				den_q[k]  <= den_q[k-1];
				quo_q[k]  <= {quo_q[k-1][QUO_W-2:0], ge};
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign out_valid = vld_q[DIV_STEPS];
	assign out_quo   = quo_q[DIV_STEPS];
	assign out_side  = side_q[DIV_STEPS];

endmodule

// ----- design/csdm_cordic.sv -----
// Pipelined rotation-mode CORDIC: one micro-rotation per stage.
module csdm_cordic import csdm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [CW-1:0]  in_vx,
	input  logic signed [ZW-1:0]  in_z,
	input  rot_side_t             in_side,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [CW-1:0]  out_vx,
	output logic signed [CW-1:0]  out_vy,
	output rot_side_t             out_side
);

	logic [ROTATION_STAGES:0] vld_q;
	logic [ROTATION_STAGES:0] rdy;
	logic signed [CW-1:0]     vx_q   [ROTATION_STAGES+1];
	logic signed [CW-1:0]     vy_q   [ROTATION_STAGES+1];
	logic signed [ZW-1:0]     z_q    [ROTATION_STAGES+1];
	rot_side_t                side_q [ROTATION_STAGES+1];

	assign vld_q[0]  = in_valid;
	assign vx_q[0]   = in_vx;
	assign vy_q[0]   = '0;
	assign z_q[0]    = in_z;
	assign side_q[0] = in_side;
	assign rdy[0]    = 1'b0;
	assign in_ready  = rdy[1];

	for (genvar k = 1; k <= ROTATION_STAGES; k++) begin : g_rot
		localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(k - 1));
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic                 pos;

		if (k == ROTATION_STAGES) begin : g_last
			assign rdy[k] = !vld_q[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !vld_q[k] || rdy[k+1];
		end

		assign dx  = vy_q[k-1] >>> (k - 1);
		assign dy  = vx_q[k-1] >>> (k - 1);
		assign pos = !z_q[k-1][ZW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_q[k-1]) begin
				vx_q[k]   <= pos ? vx_q[k-1] - dx : vx_q[k-1] + dx;
				vy_q[k]   <= pos ? vy_q[k-1] + dy : vy_q[k-1] - dy;
				z_q[k]    <= pos ? z_q[k-1] - ANG : z_q[k-1] + ANG;
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign out_valid = vld_q[ROTATION_STAGES];
	assign out_vx    = vx_q[ROTATION_STAGES];
	assign out_vy    = vy_q[ROTATION_STAGES];
	assign out_side  = side_q[ROTATION_STAGES];

endmodule

// ----- design/concentric_square_to_disk_map.sv -----
// Top level: concentric square-to-disk mapping pipeline.
// Use: one sample point (square_x, square_y) in Q2.14 enters on the input
// channel; the mapped point (disk_x, disk_y) in Q2.14 leaves on the output
// channel, one result per transfer in, in the same order.
// Both channels transfer when valid is high and stall is low at a clock edge.
// Pipeline: 4 + 30 + 16 = 50 register stages (wedge stage, gain/first
// quotient bit stage, 30 divider stages, angle stage, 16 CORDIC stages,
// output stage). Throughput: one point per cycle while out_stall is low;
// every stage is its own register and an item may enter each cycle that
// in_stall is low.
// The stage count is set by the divider (one quotient bit per stage) and
// the CORDIC (one micro-rotation per stage).
// Reset (arst_n low) empties the pipeline; no items are held.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// asserts in_stall only once every stage holds an item.
// Nothing is lost or repeated under stall.
module concentric_square_to_disk_map import csdm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [IO_W-1:0] square_x,
	input  logic signed [IO_W-1:0] square_y,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [IO_W-1:0] disk_x,
	output logic signed [IO_W-1:0] disk_y
);

	localparam logic [GAIN_W+30:0] GAIN_RND = (GAIN_W+31)'(1) << (FRAC_BITS - 1);
	localparam logic [60:0]        ANG_RND  = 61'(1) << (ANGLE_FRAC - 1);
	localparam logic signed [CW-1:0] OUT_RND =
		(OUT_SH > 0) ? (CW'(1) << (OUT_SH - 1)) : '0;
	localparam logic signed [OW-1:0] SAT_MAX = OW'(32767);
	localparam logic signed [OW-1:0] SAT_MIN = -OW'(32768);

	logic rdy1, rdy2, rdy3, rdy4;
	logic div_in_ready, div_out_valid, rot_in_ready, rot_out_valid;

	// wedge stage
	logic signed [IO_W:0] xs, ys, nxs, nys;
	wedge_t               wedge_c;
	logic signed [IO_W:0] r_c, num_c, den_c;
	logic                 v_s1;
	wedge_t               wedge_s1;
	logic                 zero_s1, qsign_s1;
	logic [MAG_W-1:0]     r_s1, num_s1, den_s1;

	assign xs  = {square_x[IO_W-1], square_x};
	assign ys  = {square_y[IO_W-1], square_y};
	assign nxs = -xs;
	assign nys = -ys;

	always_comb begin
		if (xs > nys) begin
			if (xs > ys) begin
				wedge_c = WEDGE_E; r_c = xs;  num_c = ys;  den_c = xs;
			end else begin
				wedge_c = WEDGE_N; r_c = ys;  num_c = nxs; den_c = ys;
			end
		end else begin
			if (xs < ys) begin
				wedge_c = WEDGE_W; r_c = nxs; num_c = ys;  den_c = xs;
			end else begin
				wedge_c = WEDGE_S; r_c = nys; num_c = nxs; den_c = ys;
			end
		end
	end

	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			wedge_s1 <= wedge_c;
			zero_s1  <= (r_c == '0);
			qsign_s1 <= num_c[IO_W] ^ den_c[IO_W];
			r_s1     <= r_c[MAG_W-1:0];
			num_s1   <= num_c[IO_W] ? MAG_W'(-num_c) : num_c[MAG_W-1:0];
			den_s1   <= den_c[IO_W] ? MAG_W'(-den_c) : den_c[MAG_W-1:0];
		end
	end

	// gain and first quotient bit
	logic [GAIN_W+30:0] gain_prod;
	logic               ge0;
	logic               v_s2;
	logic [MAG_W-1:0]   rem_s2, den_s2;
	logic [QUO_W-1:0]   quo_s2;
	div_side_t          side_s2;

	assign gain_prod = (GAIN_W+31)'(r_s1) * (GAIN_W+31)'(GAIN_Q30) + GAIN_RND;
	assign ge0       = num_s1 >= den_s1;
	assign rdy2      = !v_s2 || div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			rem_s2        <= ge0 ? num_s1 - den_s1 : num_s1;
			den_s2        <= den_s1;
			quo_s2        <= {{(QUO_W-1){1'b0}}, ge0};
			side_s2.wedge <= wedge_s1;
			side_s2.zero  <= zero_s1;
			side_s2.qsign <= qsign_s1;
			side_s2.vx0   <= gain_prod[FRAC_BITS +: GAIN_W];
		end
	end

	logic [QUO_W-1:0] div_quo;
	div_side_t        div_side;

	csdm_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.in_rem    (rem_s2),
		.in_den    (den_s2),
		.in_quo    (quo_s2),
		.in_side   (side_s2),
		.out_valid (div_out_valid),
		.out_ready (rdy3),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	// angle stage
	logic [60:0]          ang_prod;
	logic [ZW-1:0]        mz;
	logic                 v_s3;
	logic signed [CW-1:0] vx_s3;
	logic signed [ZW-1:0] z_s3;
	rot_side_t            side_s3;

	assign ang_prod = 61'(div_quo) * 61'(PI_QUARTER_Q30) + ANG_RND;
	assign mz       = ZW'(ang_prod[60:ANGLE_FRAC]);
	assign rdy3     = !v_s3 || rot_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && div_out_valid) begin
			vx_s3         <= CW'(div_side.vx0);
			z_s3          <= div_side.qsign ? -$signed(mz) : $signed(mz);
			side_s3.wedge <= div_side.wedge;
			side_s3.zero  <= div_side.zero;
		end
	end

	logic signed [CW-1:0] rot_vx, rot_vy;
	rot_side_t            rot_side;

	csdm_cordic u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (rot_in_ready),
		.in_vx     (vx_s3),
		.in_z      (z_s3),
		.in_side   (side_s3),
		.out_valid (rot_out_valid),
		.out_ready (rdy4),
		.out_vx    (rot_vx),
		.out_vy    (rot_vy),
		.out_side  (rot_side)
	);

	// output stage
	logic signed [CW-1:0] c_full, s_full;
	logic signed [OW-1:0] c_r, s_r, ox, oy;
	logic                 v_s4;
	logic signed [IO_W-1:0] x_s4, y_s4;

	function automatic logic signed [IO_W-1:0] sat(input logic signed [OW-1:0] v);
		logic signed [IO_W-1:0] o;
		if (v > SAT_MAX) begin
			o = IO_W'(SAT_MAX);
		end else if (v < SAT_MIN) begin
			o = IO_W'(SAT_MIN);
		end else begin
			o = v[IO_W-1:0];
		end
		return o;
	endfunction

	assign c_full = (rot_vx + OUT_RND) >>> OUT_SH;
	assign s_full = (rot_vy + OUT_RND) >>> OUT_SH;
	assign c_r    = c_full[OW-1:0];
	assign s_r    = s_full[OW-1:0];

	always_comb begin
		unique case (rot_side.wedge)
			WEDGE_E: begin ox = c_r;  oy = s_r;  end
			WEDGE_N: begin ox = -s_r; oy = c_r;  end
			WEDGE_W: begin ox = -c_r; oy = -s_r; end
			WEDGE_S: begin ox = s_r;  oy = -c_r; end
			default: begin ox = c_r;  oy = s_r;  end
		endcase
	end

	assign rdy4 = !v_s4 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= rot_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && rot_out_valid) begin
			x_s4 <= rot_side.zero ? '0 : sat(ox);
			y_s4 <= rot_side.zero ? '0 : sat(oy);
		end
	end

	assign out_valid = v_s4;
	assign disk_x    = x_s4;
	assign disk_y    = y_s4;

endmodule
